// ===== hdl/jme_pkg.sv =====
package jme_pkg;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 24;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_HOLD_MS          = 2'd0;
  localparam logic [1:0] REG_CURSOR_PERIOD_MS = 2'd1;
  localparam logic [1:0] REG_SCROLL_PERIOD_MS = 2'd2;

  localparam logic [15:0] HOLD_MS_RST          = 16'd2000;
  localparam logic [7:0]  CURSOR_PERIOD_MS_RST = 8'd8;
  localparam logic [7:0]  SCROLL_PERIOD_MS_RST = 8'd60;

  localparam logic [5:0] MOVE_ACCEL_MAX   = 6'd48;
  localparam logic [5:0] SCROLL_ACCEL_MAX = 6'd36;

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [7:0]  cursor_period_ms;
    logic [7:0]  scroll_period_ms;
  } cfg_t;

  // input item, first field in the high bits
  typedef struct packed {
    logic        host_ready;
    logic [31:0] now_ms;
    logic        sym_held;
    logic        fn_alone;
    logic [4:0]  joy_bits;
  } item_t;

  typedef struct packed {
    logic       mouse_mode;
    logic [2:0] wheel_h;
    logic [2:0] wheel_v;
    logic [4:0] move_y;
    logic [4:0] move_x;
    logic [1:0] buttons;
    logic       report_valid;
  } result_t;

  typedef struct packed {
    logic        mode_on;
    logic        hold_active;
    logic [31:0] hold_start;
    logic        hold_done;
    logic [31:0] last_move_time;
    logic [5:0]  move_accel;
    logic [31:0] last_scroll_time;
    logic [5:0]  scroll_accel;
    logic [1:0]  last_buttons;
  } state_t;

  // 1 + accel/6, accel in 0..48
  function automatic logic [3:0] move_speed(input logic [5:0] accel);
    logic [3:0] sp;
    if      (accel >= 6'd48) sp = 4'd9;
    else if (accel >= 6'd42) sp = 4'd8;
    else if (accel >= 6'd36) sp = 4'd7;
    else if (accel >= 6'd30) sp = 4'd6;
    else if (accel >= 6'd24) sp = 4'd5;
    else if (accel >= 6'd18) sp = 4'd4;
    else if (accel >= 6'd12) sp = 4'd3;
    else if (accel >= 6'd6)  sp = 4'd2;
    else                     sp = 4'd1;
    return sp;
  endfunction

  // 1 + accel/12, capped at 3
  function automatic logic [1:0] scroll_step(input logic [5:0] accel);
    logic [1:0] st;
    if      (accel >= 6'd24) st = 2'd3;
    else if (accel >= 6'd12) st = 2'd2;
    else                     st = 2'd1;
    return st;
  endfunction

endpackage

// ===== hdl/jme_regs.sv =====
module jme_regs import jme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ms          <= HOLD_MS_RST;
      cfg.cursor_period_ms <= CURSOR_PERIOD_MS_RST;
      cfg.scroll_period_ms <= SCROLL_PERIOD_MS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_HOLD_MS:          cfg.hold_ms          <= pwdata[15:0];
        REG_CURSOR_PERIOD_MS: cfg.cursor_period_ms <= pwdata[7:0];
        REG_SCROLL_PERIOD_MS: cfg.scroll_period_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOLD_MS:          prdata = {16'd0, cfg.hold_ms};
      REG_CURSOR_PERIOD_MS: prdata = {24'd0, cfg.cursor_period_ms};
      REG_SCROLL_PERIOD_MS: prdata = {24'd0, cfg.scroll_period_ms};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/jme_step.sv =====
module jme_step import jme_pkg::*; (
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  st,
  output state_t  st_next,
  output result_t res
);

  logic       x_pos, x_neg, y_pos, y_neg, moving;
  logic [1:0] btn;
  logic       hold_elapsed, scroll_due, move_due;
  logic [5:0] move_acc_inc, scroll_acc_inc;
  logic [4:0] move_mag;
  logic [2:0] wheel_mag;

  assign x_pos  = item.joy_bits[3] & ~item.joy_bits[2];
  assign x_neg  = item.joy_bits[2] & ~item.joy_bits[3];
  assign y_pos  = item.joy_bits[1] & ~item.joy_bits[0];
  assign y_neg  = item.joy_bits[0] & ~item.joy_bits[1];
  assign moving = x_pos | x_neg | y_pos | y_neg;
  assign btn    = item.joy_bits[4] ? (item.sym_held ? BTN_RIGHT : BTN_LEFT) : BTN_NONE;

  // elapsed times by wrapping unsigned difference
  assign hold_elapsed = (item.now_ms - st.hold_start) >= {16'd0, cfg.hold_ms};
  assign scroll_due   = (item.now_ms - st.last_scroll_time) >= {24'd0, cfg.scroll_period_ms};
  assign move_due     = (item.now_ms - st.last_move_time) >= {24'd0, cfg.cursor_period_ms};

  assign move_acc_inc   = (st.move_accel < MOVE_ACCEL_MAX) ? st.move_accel + 6'd1
                                                           : st.move_accel;
  assign scroll_acc_inc = (st.scroll_accel < SCROLL_ACCEL_MAX) ? st.scroll_accel + 6'd1
                                                               : st.scroll_accel;
  assign move_mag  = {1'b0, move_speed(move_acc_inc)};
  assign wheel_mag = {1'b0, scroll_step(scroll_acc_inc)};

  always_comb begin
    st_next = st;
    res     = '0;

    if (item.fn_alone) begin
      if (!st.hold_active) begin
        st_next.hold_active = 1'b1;
        st_next.hold_start  = item.now_ms;
      end else if (!st.hold_done && hold_elapsed) begin
        st_next.mode_on   = ~st.mode_on;
        st_next.hold_done = 1'b1;
      end
    end else begin
      st_next.hold_active = 1'b0;
      st_next.hold_done   = 1'b0;
    end

    if (st_next.mode_on) begin
      if (item.sym_held) begin
        st_next.move_accel = '0;
        if (moving) begin
          if (scroll_due && item.host_ready) begin
            st_next.last_scroll_time = item.now_ms;
            st_next.scroll_accel     = scroll_acc_inc;
            st_next.last_buttons     = btn;
            res.report_valid = 1'b1;
            res.buttons      = btn;
            // wheel up is positive, so joystick up gives +
            res.wheel_v = y_neg ? wheel_mag : (y_pos ? 3'(-wheel_mag) : 3'd0);
            res.wheel_h = x_pos ? wheel_mag : (x_neg ? 3'(-wheel_mag) : 3'd0);
          end
        end else begin
          st_next.scroll_accel = '0;
          if (btn != st.last_buttons) begin
            // a change offered while the host is busy is dropped
            res.report_valid     = item.host_ready;
            res.buttons          = item.host_ready ? btn : BTN_NONE;
            st_next.last_buttons = btn;
          end
        end
      end else if (move_due && item.host_ready) begin
        st_next.scroll_accel   = '0;
        st_next.last_move_time = item.now_ms;
        if (moving) begin
          st_next.move_accel   = move_acc_inc;
          st_next.last_buttons = btn;
          res.report_valid = 1'b1;
          res.buttons      = btn;
          res.move_x = x_pos ? move_mag : (x_neg ? 5'(-move_mag) : 5'd0);
          res.move_y = y_pos ? move_mag : (y_neg ? 5'(-move_mag) : 5'd0);
        end else begin
          st_next.move_accel = '0;
          if (btn != st.last_buttons) begin
            res.report_valid     = 1'b1;
            res.buttons          = btn;
            st_next.last_buttons = btn;
          end
        end
      end
    end

    res.mouse_mode = st_next.mode_on;
  end

endmodule

// ===== hdl/joystick_mouse_emulator_top.sv =====
// Joystick mouse emulator. Each input item is one polling tick and yields exactly one
// result item. The accepted tick sits in an input register, one combinational pass
// computes the report and the next mode and acceleration state, and both land in
// the result register and the state registers at the same edge. One item per clock
// is sustained while the result side is not stalled; the limit is that single state
// update loop. Back-pressure on the result side stalls the input side only when both
// registers are full. APB registers: hold_ms 0x0, cursor_period_ms 0x4, scroll_period_ms 0x8.
module joystick_mouse_emulator_top import jme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] joy_bits, [5] fn_alone, [6] sym_held, [38:7] now_ms, [39] host_ready
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] report_valid, [2:1] buttons, [7:3] move_x, [12:8] move_y,
  // [15:13] wheel_v, [18:16] wheel_h, [19] mouse_mode, [23:20] zero
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  st, st_next;
  result_t res, out_res;
  logic    advance;

  jme_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jme_step u_step (
    .item    (in_item),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      st            <= '0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = OUT_W'(out_res);

  a_quiet_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.report_valid |->
      out_res.buttons == BTN_NONE && out_res.move_x == '0 && out_res.move_y == '0 &&
      out_res.wheel_v == '0 && out_res.wheel_h == '0)
    else $error("non-report result carries payload");

  a_mode_needs_fn: assert property (@(posedge clk) disable iff (rst)
    advance && in_valid && !in_item.fn_alone |=> st.mode_on == $past(st.mode_on))
    else $error("mode changed without Fn held");

  a_accel_bounds: assert property (@(posedge clk) disable iff (rst)
    st.move_accel <= MOVE_ACCEL_MAX && st.scroll_accel <= SCROLL_ACCEL_MAX)
    else $error("acceleration out of range");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("pending input item overwritten");

endmodule

// ===== tb/jme_report_checker.sv =====
`timescale 1ns / 100ps

module jme_report_checker import jme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [4:0] joy_bits, [5] fn_alone, [6] sym_held, [38:7] now_ms, [39] host_ready
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] report_valid, [2:1] buttons, [7:3] move_x, [12:8] move_y,
  // [15:13] wheel_v, [18:16] wheel_h, [19] mouse_mode, [23:20] zero
  input  logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          waiting
);

  logic [15:0] hold_lim;
  logic [7:0]  cursor_gap;
  logic [7:0]  scroll_gap;

  logic        in_mouse;
  logic        fn_holding;
  logic        fn_toggled;
  logic [31:0] fn_since;
  logic [31:0] moved_at;
  logic [31:0] scrolled_at;
  logic [5:0]  cursor_accel;
  logic [5:0]  wheel_accel;
  logic [1:0]  prev_buttons;

  result_t report_q[$];

  // advances the emulator state by one tick and returns the report it yields
  function automatic result_t predict_report(input item_t t);
    result_t    r;
    int         dx;
    int         dy;
    int         gain;
    logic [1:0] btn;
    r = '0;
    if (t.fn_alone) begin
      if (!fn_holding) begin
        fn_holding = 1'b1;
        fn_since = t.now_ms;
      end else if (!fn_toggled && t.now_ms - fn_since >= 32'(hold_lim)) begin
        in_mouse = !in_mouse;
        fn_toggled = 1'b1;
      end
    end else begin
      fn_holding = 1'b0;
      fn_toggled = 1'b0;
    end

    if (in_mouse) begin
      // opposite directions cancel out
      dx = int'(t.joy_bits[3]) - int'(t.joy_bits[2]);
      dy = int'(t.joy_bits[1]) - int'(t.joy_bits[0]);
      btn = !t.joy_bits[4] ? BTN_NONE : (t.sym_held ? BTN_RIGHT : BTN_LEFT);
      if (t.sym_held) begin
        cursor_accel = '0;
        if (dx != 0 || dy != 0) begin
          if (t.now_ms - scrolled_at >= 32'(scroll_gap) && t.host_ready) begin
            scrolled_at = t.now_ms;
            if (wheel_accel < SCROLL_ACCEL_MAX) wheel_accel++;
            gain = 1 + wheel_accel / 12;
            if (gain > 3) gain = 3;
            r.report_valid = 1'b1;
            r.buttons = btn;
            r.wheel_v = 3'(-dy * gain);
            r.wheel_h = 3'(dx * gain);
            prev_buttons = btn;
          end
        end else begin
          wheel_accel = '0;
          // offered once, no period wait; dropped if the host is busy
          if (btn != prev_buttons) begin
            if (t.host_ready) begin
              r.report_valid = 1'b1;
              r.buttons = btn;
            end
            prev_buttons = btn;
          end
        end
      end else if (t.now_ms - moved_at >= 32'(cursor_gap) && t.host_ready) begin
        wheel_accel = '0;
        moved_at = t.now_ms;
        if (dx != 0 || dy != 0) begin
          if (cursor_accel < MOVE_ACCEL_MAX) cursor_accel++;
          gain = 1 + cursor_accel / 6;
          if (gain > 9) gain = 9;
          r.report_valid = 1'b1;
          r.buttons = btn;
          r.move_x = 5'(dx * gain);
          r.move_y = 5'(dy * gain);
          prev_buttons = btn;
        end else begin
          cursor_accel = '0;
          if (btn != prev_buttons) begin
            r.report_valid = 1'b1;
            r.buttons = btn;
            prev_buttons = btn;
          end
        end
      end
    end
    r.mouse_mode = in_mouse;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      hold_lim = HOLD_MS_RST;
      cursor_gap = CURSOR_PERIOD_MS_RST;
      scroll_gap = SCROLL_PERIOD_MS_RST;
      in_mouse = 1'b0;
      fn_holding = 1'b0;
      fn_toggled = 1'b0;
      fn_since = '0;
      moved_at = '0;
      scrolled_at = '0;
      cursor_accel = '0;
      wheel_accel = '0;
      prev_buttons = BTN_NONE;
      report_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_HOLD_MS:          hold_lim = pwdata[15:0];
          REG_CURSOR_PERIOD_MS: cursor_gap = pwdata[7:0];
          REG_SCROLL_PERIOD_MS: scroll_gap = pwdata[7:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        report_q.push_back(predict_report(item_t'(s_axis_tdata)));

      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[19:0]);
        if (report_q.size() == 0) begin
          $error("unexpected result item: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("report_valid", want.report_valid, got.report_valid);
          check_field("buttons", want.buttons, got.buttons);
          check_field("move_x", $signed(want.move_x), $signed(got.move_x));
          check_field("move_y", $signed(want.move_y), $signed(got.move_y));
          check_field("wheel_v", $signed(want.wheel_v), $signed(got.wheel_v));
          check_field("wheel_h", $signed(want.wheel_h), $signed(got.wheel_h));
          check_field("mouse_mode", want.mouse_mode, got.mouse_mode);
        end
      end
    end
    waiting = report_q.size();
  end

endmodule

// ===== tb/joystick_mouse_emulator_top_tb.sv =====
`timescale 1ns / 100ps

module joystick_mouse_emulator_top_tb import jme_pkg::*;;

  localparam logic [4:0] JOY_NONE  = 5'b00000;
  localparam logic [4:0] JOY_UP    = 5'b00001;
  localparam logic [4:0] JOY_DOWN  = 5'b00010;
  localparam logic [4:0] JOY_LEFT  = 5'b00100;
  localparam logic [4:0] JOY_RIGHT = 5'b01000;
  localparam logic [4:0] JOY_PUSH  = 5'b10000;
  localparam logic [4:0] JOY_ALL   = 5'b11111;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          waiting;

  logic        gaps_on;
  bit          stall_req;
  logic [31:0] clock_ms;
  logic [15:0] hold_cfg;
  logic [7:0]  cursor_cfg;
  logic [7:0]  scroll_cfg;
  logic [4:0]  cur_joy;
  logic        cur_sym;

  joystick_mouse_emulator_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  jme_report_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .waiting       (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit stall_seen;
    hold_left = 0;
    stall_seen = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_seen) begin
        stall_seen = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 7);
      end
    end
  end

  function automatic item_t mk(input logic [4:0] joy, input logic fn, input logic sym,
                               input logic [31:0] now, input logic ready);
    item_t t;
    t.joy_bits = joy;
    t.fn_alone = fn;
    t.sym_held = sym;
    t.now_ms = now;
    t.host_ready = ready;
    return t;
  endfunction

  // starts and ends at a falling edge
  task automatic send_tick(input item_t t);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HOLD_MS:          hold_cfg = value[15:0];
      REG_CURSOR_PERIOD_MS: cursor_cfg = value[7:0];
      REG_SCROLL_PERIOD_MS: scroll_cfg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // drain all outstanding results before touching the registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_ticks(input int n);
    item_t       t;
    logic [39:0] raw;
    logic [4:0]  sweep_joy;
    logic        sweep_sym;
    int          roll;
    int          burst;
    for (int k = 0; k < n; k += burst) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // hold Fn alone long enough for exactly one toggle
        burst = $urandom_range(3, 6);
        for (int j = 0; j < burst; j++) begin
          if (j > 0)
            clock_ms += $urandom_range(hold_cfg / 2, hold_cfg / 2 + hold_cfg / 4 + 2);
          send_tick(mk(JOY_NONE, 1'b1, 1'($urandom_range(0, 1)), clock_ms,
                       1'($urandom_range(0, 1))));
        end
      end else if (roll < 5) begin
        // steady push in one direction to run the acceleration into saturation
        burst = 60;
        sweep_joy = {1'($urandom_range(0, 1)), 4'(1 << $urandom_range(0, 3))};
        sweep_sym = 1'($urandom_range(0, 1));
        for (int j = 0; j < burst; j++) begin
          clock_ms += (sweep_sym ? scroll_cfg : cursor_cfg) + $urandom_range(0, 3);
          send_tick(mk(sweep_joy, 1'b0, sweep_sym, clock_ms, 1'b1));
        end
      end else if (roll < 12) begin
        burst = 1;
        raw[31:0] = $urandom;
        raw[39:32] = 8'($urandom_range(0, 255));
        t = raw;
        send_tick(t);
      end else begin
        burst = 1;
        if ($urandom_range(0, 9) == 0)
          cur_joy = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 31))
                                               : {1'($urandom_range(0, 1)), 4'b0000};
        if ($urandom_range(0, 14) == 0) cur_sym = !cur_sym;
        clock_ms += $urandom_range(0, 2 * (cur_sym ? scroll_cfg : cursor_cfg) + 1);
        send_tick(mk(cur_joy, $urandom_range(0, 29) == 0, cur_sym, clock_ms,
                     $urandom_range(0, 9) != 0));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    stall_req = 1'b0;
    hold_cfg = HOLD_MS_RST;
    cursor_cfg = CURSOR_PERIOD_MS_RST;
    scroll_cfg = SCROLL_PERIOD_MS_RST;
    cur_joy = JOY_NONE;
    cur_sym = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed ticks at the reset register values
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'd1000, 1'b1));  // hold starts, no toggle
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'd2999, 1'b1));
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'd3000, 1'b1));  // toggle on
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'd9000, 1'b1));  // same hold, no second toggle
    send_tick(mk(JOY_NONE, 1'b0, 1'b0, 32'd9001, 1'b1));
    send_tick(mk(JOY_UP | JOY_DOWN, 1'b0, 1'b0, 32'd9010, 1'b1));
    send_tick(mk(JOY_LEFT | JOY_RIGHT | JOY_PUSH, 1'b0, 1'b0, 32'd9020, 1'b1));
    send_tick(mk(JOY_RIGHT, 1'b0, 1'b0, 32'd9030, 1'b1));
    send_tick(mk(JOY_UP | JOY_LEFT, 1'b0, 1'b0, 32'd9031, 1'b1));
    send_tick(mk(JOY_DOWN | JOY_RIGHT | JOY_PUSH, 1'b0, 1'b0, 32'd9040, 1'b0));
    send_tick(mk(JOY_ALL, 1'b0, 1'b1, 32'd9050, 1'b1));
    send_tick(mk(JOY_PUSH, 1'b0, 1'b1, 32'd9051, 1'b0));
    send_tick(mk(JOY_NONE, 1'b0, 1'b1, 32'd9052, 1'b0));  // release lost, host busy
    send_tick(mk(JOY_NONE, 1'b0, 1'b1, 32'd9053, 1'b1));
    send_tick(mk(JOY_UP, 1'b0, 1'b1, 32'd9100, 1'b1));
    send_tick(mk(JOY_RIGHT, 1'b0, 1'b1, 32'd9110, 1'b1));
    send_tick(mk(JOY_DOWN | JOY_LEFT | JOY_PUSH, 1'b0, 1'b1, 32'd9200, 1'b1));
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'hFFFF_FFF0, 1'b1));
    send_tick(mk(JOY_NONE, 1'b1, 1'b0, 32'h0000_07C0, 1'b1));  // toggle across the wrap
    send_tick(mk(JOY_ALL, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_tick(mk(JOY_LEFT, 1'b0, 1'b0, 32'h0000_0000, 1'b1));
    clock_ms = 32'hFFFF_F000;
    random_ticks(40);
    settle();

    apb_write(REG_HOLD_MS, 32'd0);
    apb_write(REG_CURSOR_PERIOD_MS, 32'd0);
    apb_write(REG_SCROLL_PERIOD_MS, 32'd0);
    random_ticks(110);
    settle();

    apb_write(REG_HOLD_MS, 32'd65535);
    apb_write(REG_CURSOR_PERIOD_MS, 32'd255);
    apb_write(REG_SCROLL_PERIOD_MS, 32'd255);
    random_ticks(90);
    settle();

    apb_write(REG_HOLD_MS, 32'd40);
    apb_write(REG_CURSOR_PERIOD_MS, 32'd5);
    apb_write(REG_SCROLL_PERIOD_MS, 32'd20);
    gaps_on = 1'b0;
    random_ticks(80);
    gaps_on = 1'b1;
    stall_req = 1'b1;
    random_ticks(230);
    settle();

    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
